@@ src/jst_pkg.sv @@
package jst_pkg;

  // Parser modes
  typedef enum logic [3:0] {
    MD_VALUE     = 4'd0,
    MD_ARR_FIRST = 4'd1,
    MD_OBJ_FIRST = 4'd2,
    MD_KEY       = 4'd3,
    MD_STR_KEY   = 4'd4,
    MD_ESC_KEY   = 4'd5,
    MD_STR_VAL   = 4'd6,
    MD_ESC_VAL   = 4'd7,
    MD_PRIM      = 4'd8,
    MD_COLON     = 4'd9,
    MD_AFTER     = 4'd10,
    MD_DONE      = 4'd11
  } mode_t;

  localparam logic [1:0] TY_OBJECT = 2'd0;
  localparam logic [1:0] TY_ARRAY  = 2'd1;
  localparam logic [1:0] TY_STRING = 2'd2;
  localparam logic [1:0] TY_PRIM   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_UNENDED  = 3'd2;
  localparam logic [2:0] ST_DEEP     = 3'd3;
  localparam logic [2:0] ST_CAPACITY = 3'd4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Record bits carried on tdata (everything but last_result)
  localparam int REC_BITS = 86;

  // One output record
  typedef struct packed {
    logic        last_result;
    logic [15:0] token_total;
    logic [2:0]  status_code;
    logic [15:0] child_count;
    logic [15:0] end_offset;
    logic [15:0] start_offset;
    logic [1:0]  token_type;
    logic [15:0] token_index;
    logic        record_kind;
  } rec_t;

  // Stack operation sent down the cell row
  typedef struct packed {
    logic push;
    logic pop;
    logic bump;
  } stk_op_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE || c == CH_COLON;
  endfunction

endpackage

@@ src/jst_cell.sv @@
// One stack entry. Push shifts entries down the row, pop shifts them up;
// only the top cell counts children.
module jst_cell
  import jst_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  stk_op_t                op,
  input  logic                   is_top,
  input  logic [15:0]            up_index,
  input  logic [OFFSET_BITS-1:0] up_start,
  input  logic [15:0]            up_children,
  input  logic                   up_obj,
  input  logic [15:0]            dn_index,
  input  logic [OFFSET_BITS-1:0] dn_start,
  input  logic [15:0]            dn_children,
  input  logic                   dn_obj,
  output logic [15:0]            index,
  output logic [OFFSET_BITS-1:0] start,
  output logic [15:0]            children,
  output logic                   obj
);

  always_ff @(posedge clk) begin
    if (op.push) begin
      index    <= up_index;
      start    <= up_start;
      children <= up_children;
      obj      <= up_obj;
    end else if (op.pop) begin
      index    <= dn_index;
      start    <= dn_start;
      children <= dn_children;
      obj      <= dn_obj;
    end else if (op.bump && is_top) begin
      children <= children + 16'd1;
    end
  end

endmodule

@@ src/jst_stack.sv @@
// Container stack as a row of cells, top of stack in cell 0.
module jst_stack
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH   = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  stk_op_t                op,
  input  logic [15:0]            new_index,
  input  logic [OFFSET_BITS-1:0] new_start,
  input  logic                   new_obj,
  output logic [15:0]            top_index,
  output logic [OFFSET_BITS-1:0] top_start,
  output logic [15:0]            top_children,
  output logic                   top_obj
);

  logic [15:0]            c_index    [MAX_DEPTH+1];
  logic [OFFSET_BITS-1:0] c_start    [MAX_DEPTH+1];
  logic [15:0]            c_children [MAX_DEPTH+1];
  logic                   c_obj      [MAX_DEPTH+1];

  // Spare bottom slot feeds pops with don't-care data
  assign c_index[MAX_DEPTH]    = '0;
  assign c_start[MAX_DEPTH]    = '0;
  assign c_children[MAX_DEPTH] = '0;
  assign c_obj[MAX_DEPTH]      = 1'b0;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic [15:0]            u_i;
    logic [OFFSET_BITS-1:0] u_s;
    logic [15:0]            u_c;
    logic                   u_o;
    if (i == 0) begin : g_head
      assign u_i = new_index;
      assign u_s = new_start;
      assign u_c = '0;
      assign u_o = new_obj;
    end else if (i == 1) begin : g_second
      // Parent moving down counts the container opened this cycle
      assign u_i = c_index[0];
      assign u_s = c_start[0];
      assign u_c = c_children[0] + {15'd0, op.bump};
      assign u_o = c_obj[0];
    end else begin : g_body
      assign u_i = c_index[i-1];
      assign u_s = c_start[i-1];
      assign u_c = c_children[i-1];
      assign u_o = c_obj[i-1];
    end
    jst_cell #(.OFFSET_BITS(OFFSET_BITS)) u_cell (
      .clk        (clk),
      .op         (op),
      .is_top     (i == 0),
      .up_index   (u_i),
      .up_start   (u_s),
      .up_children(u_c),
      .up_obj     (u_o),
      .dn_index   (c_index[i+1]),
      .dn_start   (c_start[i+1]),
      .dn_children(c_children[i+1]),
      .dn_obj     (c_obj[i+1]),
      .index      (c_index[i]),
      .start      (c_start[i]),
      .children   (c_children[i]),
      .obj        (c_obj[i])
    );
  end

  assign top_index    = c_index[0];
  assign top_start    = c_start[0];
  assign top_children = c_children[0];
  assign top_obj      = c_obj[0];

endmodule

@@ src/json_stream_tokenizer.sv @@
// Channel   Direction  Handshake              Payload
// s_axis    in         s_axis_tvalid/tready   tdata=data_byte, tlast=last_byte
// m_axis    out        m_axis_tvalid/tready   tdata=record fields, tlast=last_result
// cfg       in         cfg_valid/cfg_ready    cfg_data=token_limit
// One byte per ready cycle; a byte updates only the top stack cell and the row shifts.
// A byte yields up to three records, queued in a four-entry output FIFO that drains
// one record per ready cycle; input stalls when fewer than three slots are free.
// rst is synchronous and clears the parser state; stack cells are never cleared.
module json_stream_tokenizer
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH   = 64,
  parameter int OFFSET_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // record_kind, token_index, token_type, start_offset, end_offset,
  // child_count, status_code, token_total (pad to 88 bits)
  output logic [87:0]  m_axis_tdata,
  output logic         m_axis_tlast,   // last_result
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [15:0]            token_limit;
  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [15:0]            cnt, cnt_next;
  logic [DW-1:0]          depth, depth_next;
  logic [OFFSET_BITS-1:0] leaf, leaf_next;

  logic [15:0]            top_index, top_children;
  logic [OFFSET_BITS-1:0] top_start;
  logic                   top_obj;
  stk_op_t                op;
  logic                   new_obj;

  rec_t        recs [3];
  logic [1:0]  nrec;

  // Output FIFO
  rec_t        fifo [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  fill;
  logic        acc;

  assign s_axis_tready = (fill <= 3'd1);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  jst_stack #(.MAX_DEPTH(MAX_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_stack (
    .clk         (clk),
    .op          (op),
    .new_index   (cnt),
    .new_start   (pos),
    .new_obj     (new_obj),
    .top_index   (top_index),
    .top_start   (top_start),
    .top_children(top_children),
    .top_obj     (top_obj)
  );

  // Byte processing, following the parser step by step
  always_comb begin
    logic [7:0] c;
    logic       done;
    logic       ok;
    logic       prim_after;
    c          = s_axis_tdata;
    mode_next  = mode;
    pos_next   = pos;
    cnt_next   = cnt;
    depth_next = depth;
    leaf_next  = leaf;
    op         = '0;
    new_obj    = 1'b0;
    nrec       = 2'd0;
    done       = 1'b0;
    ok         = 1'b0;
    prim_after = 1'b0;
    for (int k = 0; k < 3; k++) recs[k] = '0;

    if (acc) begin
      if (mode != MD_DONE) begin
        if (pos == POS_MAX) begin
          recs[0] = '{record_kind:1'b1, status_code:ST_CAPACITY, token_total:cnt,
                      default:'0};
          nrec = 2'd1; mode_next = MD_DONE;
        end else begin
          unique case (mode)
            MD_VALUE, MD_ARR_FIRST: begin
              if (is_ws(c)) begin
              end else if (mode == MD_ARR_FIRST && c == CH_RBRACK) begin
                ok = 1'b1;
              end else if (c == CH_LBRACE || c == CH_LBRACK) begin
                if (cnt >= token_limit) begin
                  recs[0] = '{record_kind:1'b1, status_code:ST_CAPACITY,
                              token_total:cnt, default:'0};
                  nrec = 2'd1; mode_next = MD_DONE;
                end else begin
                  cnt_next = cnt + 16'd1;
                  if (int'(depth) >= MAX_DEPTH) begin
                    recs[0] = '{record_kind:1'b1, status_code:ST_DEEP,
                                token_total:cnt + 16'd1, default:'0};
                    nrec = 2'd1; mode_next = MD_DONE;
                  end else begin
                    op.push    = 1'b1;
                    op.bump    = (depth != '0);
                    new_obj    = (c == CH_LBRACE);
                    depth_next = depth + 1'b1;
                    mode_next  = (c == CH_LBRACE) ? MD_OBJ_FIRST : MD_ARR_FIRST;
                  end
                end
              end else if (c == CH_QUOTE) begin
                leaf_next = pos + 1'b1; mode_next = MD_STR_VAL;
              end else if (is_term(c)) begin
                recs[0] = '{record_kind:1'b1, status_code:ST_BAD, token_total:cnt,
                            default:'0};
                nrec = 2'd1; mode_next = MD_DONE;
              end else begin
                leaf_next = pos; mode_next = MD_PRIM;
              end
            end
            MD_OBJ_FIRST, MD_KEY: begin
              if (is_ws(c)) begin
              end else if (c == CH_RBRACE && mode == MD_OBJ_FIRST) begin
                ok = 1'b1;
              end else if (c == CH_QUOTE) begin
                leaf_next = pos + 1'b1; mode_next = MD_STR_KEY;
              end else begin
                recs[0] = '{record_kind:1'b1, status_code:ST_BAD, token_total:cnt,
                            default:'0};
                nrec = 2'd1; mode_next = MD_DONE;
              end
            end
            MD_STR_KEY, MD_STR_VAL: begin
              if (c == CH_BSLASH) begin
                mode_next = (mode == MD_STR_KEY) ? MD_ESC_KEY : MD_ESC_VAL;
              end else if (c == CH_QUOTE) begin
                if (cnt >= token_limit) begin
                  recs[0] = '{record_kind:1'b1, status_code:ST_CAPACITY,
                              token_total:cnt, default:'0};
                  nrec = 2'd1; mode_next = MD_DONE;
                end else begin
                  cnt_next = cnt + 16'd1;
                  op.bump  = (depth != '0);
                  recs[0] = '{record_kind:1'b0, token_index:cnt, token_type:TY_STRING,
                              start_offset:16'(leaf), end_offset:16'(pos),
                              default:'0};
                  nrec = 2'd1;
                  if (mode == MD_STR_KEY) mode_next = MD_COLON;
                  else if (depth == '0) begin
                    recs[1] = '{record_kind:1'b1, status_code:ST_OK,
                                token_total:cnt + 16'd1, default:'0};
                    nrec = 2'd2; mode_next = MD_DONE;
                  end else mode_next = MD_AFTER;
                end
              end
            end
            MD_ESC_KEY: mode_next = MD_STR_KEY;
            MD_ESC_VAL: mode_next = MD_STR_VAL;
            MD_PRIM: begin
              if (is_ws(c) || is_term(c)) begin
                if (cnt >= token_limit) begin
                  recs[0] = '{record_kind:1'b1, status_code:ST_CAPACITY,
                              token_total:cnt, default:'0};
                  nrec = 2'd1; mode_next = MD_DONE;
                end else begin
                  cnt_next = cnt + 16'd1;
                  op.bump  = (depth != '0);
                  recs[0] = '{record_kind:1'b0, token_index:cnt, token_type:TY_PRIM,
                              start_offset:16'(leaf), end_offset:16'(pos),
                              default:'0};
                  nrec = 2'd1;
                  if (depth == '0) begin
                    recs[1] = '{record_kind:1'b1, status_code:ST_OK,
                                token_total:cnt + 16'd1, default:'0};
                    nrec = 2'd2; mode_next = MD_DONE;
                  end else begin
                    mode_next  = MD_AFTER;
                    prim_after = 1'b1;
                  end
                end
              end
            end
            MD_COLON: begin
              if (is_ws(c)) begin
              end else if (c == CH_COLON) mode_next = MD_VALUE;
              else begin
                recs[0] = '{record_kind:1'b1, status_code:ST_BAD, token_total:cnt,
                            default:'0};
                nrec = 2'd1; mode_next = MD_DONE;
              end
            end
            MD_AFTER: prim_after = 1'b1;
            default: begin
            end
          endcase

          // After-value handling, also reached when a primitive ends
          if (prim_after && !is_ws(c)) begin
            if (depth == '0) begin
              recs[nrec] = '{record_kind:1'b1, status_code:ST_BAD,
                             token_total:cnt_next, default:'0};
              nrec = nrec + 2'd1; mode_next = MD_DONE;
            end else if (c == CH_COMMA) begin
              mode_next = top_obj ? MD_KEY : MD_VALUE;
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
              ok = 1'b1;
            end else begin
              recs[nrec] = '{record_kind:1'b1, status_code:ST_BAD,
                             token_total:cnt_next, default:'0};
              nrec = nrec + 2'd1; mode_next = MD_DONE;
            end
          end

          // Container close; the child count adds a primitive that ends on this byte
          if (ok) begin
            if (depth == '0 || (top_obj != (c == CH_RBRACE))) begin
              recs[nrec] = '{record_kind:1'b1, status_code:ST_BAD,
                             token_total:cnt_next, default:'0};
              nrec = nrec + 2'd1; mode_next = MD_DONE;
            end else begin
              op.pop     = 1'b1;
              op.bump    = 1'b0;
              depth_next = depth - 1'b1;
              recs[nrec] = '{record_kind:1'b0, token_index:top_index,
                             token_type:(c == CH_RBRACE) ? TY_OBJECT : TY_ARRAY,
                             start_offset:16'(top_start), end_offset:16'(pos + 1'b1),
                             child_count:top_children + (prim_after && mode == MD_PRIM
                                                          ? 16'd1 : 16'd0),
                             default:'0};
              nrec = nrec + 2'd1;
              if (depth == DW'(1)) begin
                recs[nrec] = '{record_kind:1'b1, status_code:ST_OK,
                               token_total:cnt_next, default:'0};
                nrec = nrec + 2'd1; mode_next = MD_DONE;
              end else mode_next = MD_AFTER;
            end
          end
        end
      end

      // End of document
      if (s_axis_tlast) begin
        if (mode_next == MD_PRIM) begin
          if (cnt_next >= token_limit) begin
            recs[nrec] = '{record_kind:1'b1, status_code:ST_CAPACITY,
                           token_total:cnt_next, default:'0};
            nrec = nrec + 2'd1;
          end else begin
            recs[nrec] = '{record_kind:1'b0, token_index:cnt_next, token_type:TY_PRIM,
                           start_offset:16'(leaf_next), end_offset:16'(pos + 1'b1),
                           default:'0};
            recs[nrec + 2'd1] = '{record_kind:1'b1,
                                  status_code:(depth_next == '0) ? ST_OK : ST_UNENDED,
                                  token_total:cnt_next + 16'd1, default:'0};
            nrec = nrec + 2'd2;
          end
        end else if (mode_next != MD_DONE) begin
          recs[nrec] = '{record_kind:1'b1, status_code:ST_UNENDED,
                         token_total:cnt_next, default:'0};
          nrec = nrec + 2'd1;
        end
        mode_next  = MD_VALUE;
        pos_next   = '0;
        cnt_next   = '0;
        depth_next = '0;
        leaf_next  = '0;
      end else if (pos != POS_MAX) begin
        pos_next = pos + 1'b1;
      end
      if (nrec != 2'd0) recs[nrec - 2'd1].last_result = 1'b1;
    end
  end

  // Parser state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MD_VALUE;
      pos         <= '0;
      cnt         <= '0;
      depth       <= '0;
      leaf        <= '0;
      token_limit <= 16'hFFFF;
    end else begin
      mode  <= mode_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
      depth <= depth_next;
      leaf  <= leaf_next;
      if (cfg_valid && cfg_ready) token_limit <= cfg_data;
    end
  end

  // FIFO write and read
  logic pop_out;
  assign pop_out       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (fill != 3'd0);
  assign m_axis_tdata  = {2'b00, fifo[rd_ptr][REC_BITS-1:0]};
  assign m_axis_tlast  = fifo[rd_ptr].last_result;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++)
      if (2'(k) < nrec) fifo[wr_ptr + 2'(k)] <= recs[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + nrec;
      if (pop_out) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, nrec} - {2'b0, pop_out};
    end
  end

  // Checks
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 3'd4)
    else $error("output queue overflow");
  a_depth: assert property (@(posedge clk) disable iff (rst) int'(depth) <= MAX_DEPTH)
    else $error("stack depth beyond limit");
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    acc && s_axis_tlast |=> pos == '0 && depth == '0)
    else $error("no re-arm after last byte");

endmodule

@@ tb/json_stream_tokenizer_tb.sv @@
module json_stream_tokenizer_tb;
  import jst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One record as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [15:0] idx;
    logic [1:0]  ty;
    logic [15:0] st;
    logic [15:0] en;
    logic [15:0] ch;
    logic [2:0]  code;
    logic [15:0] total;
    logic        last;
  } tok_rec_t;

  localparam int STACK_DEPTH = 64;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  json_stream_tokenizer u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Tokenizer shadow state
  mode_t       pm;
  logic [15:0] pos_cnt, tok_cnt, leaf_st;
  logic [15:0] tok_lim = 16'hFFFF;
  int          depth;
  logic [15:0] stk_idx [STACK_DEPTH];
  logic [15:0] stk_st  [STACK_DEPTH];
  logic [15:0] stk_ch  [STACK_DEPTH];
  logic        stk_obj [STACK_DEPTH];

  tok_rec_t    step_recs[$];
  tok_rec_t    expected_recs[$];
  logic [7:0]  doc_bytes[$];

  int  errors = 0;
  int  items_sent = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE || c == CH_COLON;
  endfunction

  function automatic void emit(logic kind, logic [15:0] idx, logic [1:0] ty,
                               logic [15:0] st, logic [15:0] en, logic [15:0] ch,
                               logic [2:0] code, logic [15:0] total);
    tok_rec_t r;
    if (step_recs.size() >= 3) return;
    r = '{kind, idx, ty, st, en, ch, code, total, 1'b0};
    step_recs.push_back(r);
  endfunction

  function automatic void end_doc(logic [2:0] code);
    emit(1'b1, '0, '0, '0, '0, '0, code, tok_cnt);
    pm = MD_DONE;
  endfunction

  function automatic bit alloc_token(output logic [15:0] idx);
    if (tok_cnt >= tok_lim) begin
      end_doc(ST_CAPACITY);
      return 1'b0;
    end
    idx = tok_cnt;
    tok_cnt++;
    if (depth > 0) stk_ch[depth-1]++;
    return 1'b1;
  endfunction

  function automatic void value_complete();
    if (depth == 0) end_doc(ST_OK);
    else pm = MD_AFTER;
  endfunction

  function automatic bit close_leaf(logic [1:0] ty, logic [15:0] en);
    logic [15:0] idx;
    if (!alloc_token(idx)) return 1'b0;
    emit(1'b0, idx, ty, leaf_st, en, '0, ST_OK, '0);
    return 1'b1;
  endfunction

  function automatic void open_box(bit obj, logic [15:0] p);
    logic [15:0] idx;
    if (!alloc_token(idx)) return;
    if (depth >= STACK_DEPTH) begin
      end_doc(ST_DEEP);
      return;
    end
    stk_idx[depth] = idx;
    stk_st[depth]  = p;
    stk_ch[depth]  = '0;
    stk_obj[depth] = obj;
    depth++;
    pm = obj ? MD_OBJ_FIRST : MD_ARR_FIRST;
  endfunction

  function automatic void close_box(bit obj, logic [15:0] p);
    int d;
    if (depth == 0) begin
      end_doc(ST_BAD);
      return;
    end
    d = depth - 1;
    if (stk_obj[d] != obj) begin
      end_doc(ST_BAD);
      return;
    end
    depth = d;
    emit(1'b0, stk_idx[d], obj ? TY_OBJECT : TY_ARRAY, stk_st[d], p + 16'd1,
         stk_ch[d], ST_OK, '0);
    value_complete();
  endfunction

  function automatic void begin_value(logic [7:0] c, logic [15:0] p);
    if (c == CH_LBRACE) open_box(1'b1, p);
    else if (c == CH_LBRACK) open_box(1'b0, p);
    else if (c == CH_QUOTE) begin
      leaf_st = p + 16'd1;
      pm = MD_STR_VAL;
    end else if (is_delim(c)) end_doc(ST_BAD);
    else begin
      leaf_st = p;
      pm = MD_PRIM;
    end
  endfunction

  function automatic void after_val(logic [7:0] c, logic [15:0] p);
    if (is_space(c)) return;
    if (depth == 0) begin
      end_doc(ST_BAD);
      return;
    end
    if (c == CH_COMMA) pm = stk_obj[depth-1] ? MD_KEY : MD_VALUE;
    else if (c == CH_RBRACE) close_box(1'b1, p);
    else if (c == CH_RBRACK) close_box(1'b0, p);
    else end_doc(ST_BAD);
  endfunction

  function automatic void take_byte(logic [7:0] c, logic [15:0] p);
    case (pm)
      MD_VALUE: if (!is_space(c)) begin_value(c, p);
      MD_ARR_FIRST: begin
        if (!is_space(c)) begin
          if (c == CH_RBRACK) close_box(1'b0, p);
          else begin_value(c, p);
        end
      end
      MD_OBJ_FIRST, MD_KEY: begin
        if (!is_space(c)) begin
          if (c == CH_RBRACE && pm == MD_OBJ_FIRST) close_box(1'b1, p);
          else if (c == CH_QUOTE) begin
            leaf_st = p + 16'd1;
            pm = MD_STR_KEY;
          end else end_doc(ST_BAD);
        end
      end
      MD_STR_KEY, MD_STR_VAL: begin
        if (c == CH_BSLASH) pm = (pm == MD_STR_KEY) ? MD_ESC_KEY : MD_ESC_VAL;
        else if (c == CH_QUOTE) begin
          bit key;
          key = (pm == MD_STR_KEY);
          if (close_leaf(TY_STRING, p)) begin
            if (key) pm = MD_COLON;
            else value_complete();
          end
        end
      end
      MD_ESC_KEY: pm = MD_STR_KEY;
      MD_ESC_VAL: pm = MD_STR_VAL;
      MD_PRIM: begin
        if (is_space(c) || is_delim(c)) begin
          if (close_leaf(TY_PRIM, p)) begin
            value_complete();
            if (pm == MD_AFTER) after_val(c, p);
          end
        end
      end
      MD_COLON: begin
        if (!is_space(c)) begin
          if (c == CH_COLON) pm = MD_VALUE;
          else end_doc(ST_BAD);
        end
      end
      MD_AFTER: after_val(c, p);
      default: ;
    endcase
  endfunction

  function automatic void new_doc();
    pm = MD_VALUE;
    pos_cnt = '0;
    tok_cnt = '0;
    depth = 0;
    leaf_st = '0;
  endfunction

  // Expected records for one accepted byte
  function automatic void predict_records(logic [7:0] c, logic lst);
    logic [15:0] p;
    p = pos_cnt;
    step_recs.delete();
    if (pm != MD_DONE) begin
      if (p == 16'hFFFF) end_doc(ST_CAPACITY);
      else take_byte(c, p);
    end
    if (lst) begin
      if (pm == MD_PRIM) begin
        if (close_leaf(TY_PRIM, p + 16'd1)) end_doc(depth == 0 ? ST_OK : ST_UNENDED);
      end else if (pm != MD_DONE) end_doc(ST_UNENDED);
      new_doc();
    end else if (p != 16'hFFFF) pos_cnt = p + 16'd1;
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last = 1'b1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endfunction

  task automatic report_err(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Output side: random ready stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // Record checker
  always @(posedge clk) begin
    tok_rec_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[18:17],
              m_axis_tdata[34:19], m_axis_tdata[50:35], m_axis_tdata[66:51],
              m_axis_tdata[69:67], m_axis_tdata[85:70], m_axis_tlast};
      if (expected_recs.size() == 0)
        report_err($sformatf("unexpected record %p", got));
      else begin
        want = expected_recs.pop_front();
        if (got.kind !== want.kind || got.idx !== want.idx || got.ty !== want.ty ||
            got.st !== want.st || got.en !== want.en || got.ch !== want.ch ||
            got.code !== want.code || got.total !== want.total || got.last !== want.last)
          report_err($sformatf("got %p want %p", got, want));
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic lst);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    predict_records(b, lst);
    items_sent++;
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_doc_bytes();
    foreach (doc_bytes[i]) send_item(doc_bytes[i], i == doc_bytes.size() - 1);
    doc_bytes.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
    send_doc_bytes();
  endtask

  // Stop input, wait until every record is out, then wait on for trailing work
  task automatic wait_drained();
    idle_input();
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tok_lim = v;
  endtask

  // Random document builder
  function automatic void add_ws();
    logic [7:0] wsp [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      doc_bytes.push_back(wsp[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_string();
    logic [7:0] c;
    doc_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(32, 126));
      if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 9) == 0)
        doc_bytes.push_back(CH_BSLASH);
      doc_bytes.push_back(c);
    end
    doc_bytes.push_back(CH_QUOTE);
  endfunction

  function automatic void add_value(int lvl);
    logic [7:0] c;
    int n, pick;
    add_ws();
    pick = (lvl >= 3) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    case (pick)
      0: repeat ($urandom_range(1, 4)) begin
        do c = 8'($urandom_range(33, 255));
        while (is_delim(c) || c == CH_QUOTE || c == CH_LBRACE || c == CH_LBRACK ||
               c == CH_RBRACE || c == CH_RBRACK);
        doc_bytes.push_back(c);
      end
      1: add_string();
      2: begin
        doc_bytes.push_back(CH_LBRACK);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc_bytes.push_back(CH_COMMA);
          add_value(lvl + 1);
        end
        add_ws();
        doc_bytes.push_back(CH_RBRACK);
      end
      default: begin
        doc_bytes.push_back(CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) doc_bytes.push_back(CH_COMMA);
          add_ws();
          add_string();
          add_ws();
          doc_bytes.push_back(CH_COLON);
          add_value(lvl + 1);
        end
        add_ws();
        doc_bytes.push_back(CH_RBRACE);
      end
    endcase
    add_ws();
  endfunction

  // Directed: structure, separators, end-of-input cases
  task automatic test_directed();
    send_text("{\"k\":[1,\"s\\\"x\"],\"e\":{} , \"a\":[]}");
    send_text("[]");
    send_text(" \t\r\n");
    send_text("]");
    send_text("[1,]");
    send_text("{\"a\" 1}");
    send_text("[}");
    send_text("{]");
    send_text("{,}");
    send_text("12");
    send_text("[1");
    send_text("\"ab");
    send_text("5 x]]");
    send_text("[tru:1]");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // Nesting beyond the stack, then to its full depth
  task automatic test_depth();
    for (int i = 0; i <= STACK_DEPTH; i++) doc_bytes.push_back(CH_LBRACK);
    send_doc_bytes();
    for (int i = 0; i < STACK_DEPTH; i++) doc_bytes.push_back(CH_LBRACK);
    for (int i = 0; i < STACK_DEPTH; i++) doc_bytes.push_back(CH_RBRACK);
    send_doc_bytes();
  endtask

  // Token limit at its extremes and at a small value
  task automatic test_limit();
    write_limit(16'd1);
    send_text("[1]");
    send_text("7");
    write_limit(16'd3);
    send_text("{\"a\":1,\"b\":2}");
    write_limit(16'hFFFF);
    send_text("[1,2]");
  endtask

  task automatic test_random();
    int dice;
    while (items_sent < 360) begin
      if ($urandom_range(0, 9) == 0) begin
        dice = $urandom_range(0, 4);
        write_limit(dice == 0 ? 16'd1 : dice == 1 ? 16'd65535 :
                    dice == 2 ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(2, 8)));
      end
      dice = $urandom_range(0, 9);
      if (dice == 0) begin
        repeat ($urandom_range(1, 8)) doc_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_value(0);
        if (dice == 1) doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] =
                         8'($urandom_range(0, 255));
        else if (dice == 2 && doc_bytes.size() > 1)
          doc_bytes = doc_bytes[0:$urandom_range(0, doc_bytes.size() - 2)];
      end
      send_doc_bytes();
    end
    write_limit(16'hFFFF);
  endtask

  task automatic test_full_rate();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (6) begin
      add_value(0);
      send_doc_bytes();
    end
  endtask

  initial begin
    new_doc();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_depth();
    test_limit();
    test_random();
    test_full_rate();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (expected_recs.size() != 0)
        report_err($sformatf("%0d records never arrived", expected_recs.size()));
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
